// ===== hdl/tam_pkg.sv =====
// shared types, constants and codes for the thermometer average monitor
package tam_pkg;

   // block length default
   localparam int BLOCK_SAMPLES_DEF = 24;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_DIST  = 2'd2;

   localparam logic signed [7:0] LOW_LIMIT_RESET  = 8'sd20;
   localparam logic signed [7:0] HIGH_LIMIT_RESET = 8'sd30;
   localparam logic [15:0]       NEAR_DIST_RESET  = 16'd40;

   // temperature class codes
   localparam logic [1:0] CLASS_HIGH   = 2'd0;
   localparam logic [1:0] CLASS_LOW    = 2'd1;
   localparam logic [1:0] CLASS_NORMAL = 2'd2;
   localparam logic [1:0] CLASS_WAIT   = 2'd3;

   // display message codes
   localparam logic [1:0] MSG_CUR_AND_AVG = 2'd0;
   localparam logic [1:0] MSG_AVG_ONLY    = 2'd1;
   localparam logic [1:0] MSG_PLEASE_WAIT = 2'd2;
   localparam logic [1:0] MSG_CLASS_ONLY  = 2'd3;

   // echo to cm: floor(echo * 17 / 1000) as (echo * 17 * ceil(2^35 / 1000)) >> 35
   localparam int ECHO_W     = 20;
   localparam int DIST_SHIFT = 35;
   localparam int DIST_MUL_W = 30;
   localparam logic [DIST_MUL_W-1:0] DIST_MUL = 30'd584115563;

   typedef struct packed {
      logic              sample_valid;
      logic signed [15:0] raw_temp;
      logic              echo_valid;
      logic [ECHO_W-1:0] echo_time_us;
   } req_type;

   typedef struct packed {
      logic [1:0]         temp_class;
      logic               led_red;
      logic               led_green;
      logic               led_blue;
      logic [1:0]         display_message;
      logic signed [15:0] current_temp;
      logic signed [15:0] average_temp;
      logic               average_ready;
      logic [15:0]        distance_cm;
   } rsp_type;

   typedef struct packed {
      logic signed [7:0] low_limit_deg;
      logic signed [7:0] high_limit_deg;
      logic [15:0]       near_distance_cm;
   } cfg_type;

   // averaging state as seen after the current word
   typedef struct packed {
      logic signed [15:0] temperature;
      logic signed [15:0] average;
      logic               ready;
      logic               past_two;
   } avg_status_type;

endpackage

// ===== hdl/tam_echo_dist.sv =====
// echo time to distance conversion and held distance
module tam_echo_dist (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        echo_valid,
   input  logic [tam_pkg::ECHO_W-1:0]  echo_time_us,
   output logic [15:0]                 distance_cm
);
   import tam_pkg::*;

   localparam int PROD_W = ECHO_W + DIST_MUL_W;

   logic [PROD_W-1:0] prod;
   logic [15:0]       dist_ff;
   logic [15:0]       dist_in;

   assign prod = PROD_W'(echo_time_us) * PROD_W'(DIST_MUL);

   always_comb begin
      dist_in = dist_ff;
      if (step && echo_valid) begin
         dist_in = 16'(prod[PROD_W-1:DIST_SHIFT]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= '0;
      end else begin
         dist_ff <= dist_in;
      end
   end

   assign distance_cm = dist_in;

endmodule

// ===== hdl/tam_block_avg.sv =====
// sample accumulator, block counter and truncated block average
module tam_block_avg #(
   parameter int BLOCK_SAMPLES = tam_pkg::BLOCK_SAMPLES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    sample_valid,
   input  logic signed [15:0]      raw_temp,
   output tam_pkg::avg_status_type status
);
   import tam_pkg::*;

   localparam int IDX_W   = $clog2(BLOCK_SAMPLES);
   localparam int SUM_W   = 16 + IDX_W;
   localparam int K       = SUM_W + IDX_W;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP =
      ((64'd1 << K) + 64'(BLOCK_SAMPLES) - 64'd1) / 64'(BLOCK_SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
   localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(BLOCK_SAMPLES - 1);
   localparam logic [IDX_W-1:0]   TWO_IDX  = IDX_W'(2);

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic signed [15:0]      avg_ff, avg_in;
   logic                    ready_ff, ready_in;
   logic signed [15:0]      temp_ff, temp_in;

   logic signed [SUM_W-1:0] total;
   logic [SUM_W-1:0]        mag;
   logic [PROD_W-1:0]       prod;
   logic [15:0]             quot;
   logic signed [15:0]      avg_new;

   // divide by the block length through a reciprocal, truncating toward zero
   assign total   = sum_ff + SUM_W'(raw_temp);
   assign mag     = total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
   assign prod    = PROD_W'(mag) * PROD_W'(RECIP_C);
   assign quot    = 16'(prod[PROD_W-1:K]);
   assign avg_new = total[SUM_W-1] ? 16'(-quot) : 16'(quot);

   always_comb begin
      sum_in   = sum_ff;
      idx_in   = idx_ff;
      avg_in   = avg_ff;
      ready_in = ready_ff;
      temp_in  = temp_ff;
      if (step && sample_valid) begin
         temp_in = raw_temp;
         if (idx_ff >= LAST_IDX) begin
            sum_in   = '0;
            idx_in   = '0;
            avg_in   = avg_new;
            ready_in = 1'b1;
         end else begin
            sum_in = total;
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         idx_ff   <= '0;
         avg_ff   <= '0;
         ready_ff <= 1'b0;
         temp_ff  <= '0;
      end else begin
         sum_ff   <= sum_in;
         idx_ff   <= idx_in;
         avg_ff   <= avg_in;
         ready_ff <= ready_in;
         temp_ff  <= temp_in;
      end
   end

   assign status.temperature = temp_in;
   assign status.average     = avg_in;
   assign status.ready       = ready_in;
   assign status.past_two    = idx_in > TWO_IDX;

endmodule

// ===== hdl/tam_classify.sv =====
// temperature class, leds and display message selection
module tam_classify (
   input  tam_pkg::cfg_type        cfg,
   input  tam_pkg::avg_status_type status,
   input  logic [15:0]             distance_cm,
   output tam_pkg::rsp_type        rsp
);
   import tam_pkg::*;

   logic signed [15:0] high_lim;
   logic signed [15:0] low_lim;
   logic               close;

   assign high_lim = {{4{cfg.high_limit_deg[7]}}, cfg.high_limit_deg, 4'b0000};
   assign low_lim  = {{4{cfg.low_limit_deg[7]}}, cfg.low_limit_deg, 4'b0000};
   assign close    = distance_cm <= cfg.near_distance_cm;

   always_comb begin
      rsp               = '0;
      rsp.current_temp  = status.temperature;
      rsp.average_temp  = status.average;
      rsp.average_ready = status.ready;
      rsp.distance_cm   = distance_cm;

      // high wins when the limits cross
      if (status.temperature > high_lim) begin
         rsp.temp_class = CLASS_HIGH;
         rsp.led_red    = 1'b1;
      end else if (status.temperature < low_lim) begin
         rsp.temp_class = CLASS_LOW;
         rsp.led_blue   = 1'b1;
      end else begin
         rsp.temp_class = CLASS_NORMAL;
         rsp.led_green  = 1'b1;
      end

      if (close && status.ready) begin
         rsp.display_message = MSG_CUR_AND_AVG;
      end else if (!close && (status.past_two || !status.ready)) begin
         rsp.display_message = MSG_CLASS_ONLY;
      end else if ((distance_cm < cfg.near_distance_cm) && !status.ready) begin
         rsp.display_message = MSG_PLEASE_WAIT;
         rsp.temp_class      = CLASS_WAIT;
      end else begin
         rsp.display_message = MSG_AVG_ONLY;
      end
   end

endmodule

// ===== hdl/thermometer_average_monitor_core.sv =====
// top level: input stage, averaging and distance state, result register
// a word accepted into the input stage moves on to the result register, where it is taken on the result side
// throughput: one word per cycle while rsp_stall is low; the input stage and result register let a
//   new word enter while a finished result waits under stall
// the path from the input stage to the result register holds one multiply each
//   for the block average and the echo conversion
// reset clears the pipeline valids, the block state and held values to zero,
//   and loads the limit and near-distance registers with their defaults
module thermometer_average_monitor_core #(
   parameter int BLOCK_SAMPLES = tam_pkg::BLOCK_SAMPLES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tam_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tam_pkg::rsp_type                rsp_data,
   input  logic                            csr_write,
   input  logic [tam_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tam_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tam_pkg::*;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic           out_ready;
   logic           advance;
   logic           accept;
   avg_status_type status;
   logic [15:0]    distance;
   rsp_type        rsp_next;

   // handshake: the input stage moves on whenever the result register is free or its result is taken
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = out_ready ? in_valid_ff : 1'b1;
   end

   // register writes, indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LOW_LIMIT:  cfg_in.low_limit_deg    = 8'(csr_wdata);
            CSR_HIGH_LIMIT: cfg_in.high_limit_deg   = 8'(csr_wdata);
            CSR_NEAR_DIST:  cfg_in.near_distance_cm = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         cfg_ff.low_limit_deg    <= LOW_LIMIT_RESET;
         cfg_ff.high_limit_deg   <= HIGH_LIMIT_RESET;
         cfg_ff.near_distance_cm <= NEAR_DIST_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   // block state updates as the word leaves the input stage
   tam_block_avg #(
      .BLOCK_SAMPLES(BLOCK_SAMPLES)
   ) u_avg (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .sample_valid (in_data_ff.sample_valid),
      .raw_temp     (in_data_ff.raw_temp),
      .status       (status)
   );

   tam_echo_dist u_dist (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .echo_valid   (in_data_ff.echo_valid),
      .echo_time_us (in_data_ff.echo_time_us),
      .distance_cm  (distance)
   );

   tam_classify u_class (
      .cfg         (cfg_ff),
      .status      (status),
      .distance_cm (distance),
      .rsp         (rsp_next)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // leds always one-hot on a valid word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_data.led_red, rsp_data.led_green, rsp_data.led_blue}))
      else $error("leds not one-hot");

   // waiting class only comes with the please-wait message before the first average
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.temp_class == CLASS_WAIT) |->
         (rsp_data.display_message == MSG_PLEASE_WAIT) && !rsp_data.average_ready)
      else $error("waiting class without please-wait message");

   // current-and-average message needs a ready average
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.display_message == MSG_CUR_AND_AVG) |->
         rsp_data.average_ready)
      else $error("average shown before it is ready");

   // a word in the input stage with a free result register is delivered next cycle
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_ready |=> rsp_valid)
      else $error("word lost between input stage and result register");

endmodule
